// ===== hdl/bsc_pkg.sv =====
// Shared types and constants of the top-3 min/max tracker and bar scaler.
`timescale 1ns / 1ps

package bsc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 16;
    localparam int WIDTH_W  = 10;
    localparam int BAR_W    = 9;
    localparam int SPAN_W   = 9;

    // Scaling constants
    localparam int RANGE_LIMIT = 112;
    localparam int MAG_W       = $clog2(RANGE_LIMIT + 1);
    localparam int PROD_W      = MAG_W + SPAN_W;

    // Divide by RANGE_LIMIT as a multiply by a rounded-up reciprocal.
    // Exact while product * (rounding error) < 2^shift, i.e. for all PROD_W-bit products.
    localparam int RECIP_SHIFT = PROD_W + MAG_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(RANGE_LIMIT) - 64'd1) / 64'(RANGE_LIMIT));

    // Display width limits and reset value
    localparam logic [WIDTH_W-1:0] WIDTH_MIN     = WIDTH_W'(5);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX     = WIDTH_W'(512);
    localparam logic [WIDTH_W-1:0] BAR_MARGIN    = WIDTH_W'(4);
    localparam logic [WIDTH_W-1:0] DISPLAY_RESET = WIDTH_W'(80);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // End-of-set sentinel sample
    localparam t_sample SENTINEL = 16'sd9999;

    // Item after the tracker update, before the bar divide
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              over;
        logic              end_mark;
        t_sample           low0;
        t_sample           low1;
        t_sample           low2;
        t_sample           high0;
        t_sample           high1;
        t_sample           high2;
        logic [CNT_W-1:0]  inv_cnt;
        logic [CNT_W-1:0]  pos_cnt;
    } t_stage1;

    // Finished result item
    typedef struct packed {
        logic [BAR_W-1:0]  bar;
        logic              neg;
        logic              over;
        logic              end_mark;
        t_sample           low0;
        t_sample           low1;
        t_sample           low2;
        t_sample           high0;
        t_sample           high1;
        t_sample           high2;
        logic [CNT_W-1:0]  inv_cnt;
        logic [CNT_W-1:0]  pos_cnt;
    } t_result;

endpackage

// ===== hdl/bsc_update.sv =====
// Tracker and counter state, per-item update and the magnitude * span product.
`timescale 1ns / 1ps

module bsc_update
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  t_sample             i_sample,
    input  logic                i_first,
    input  logic [WIDTH_W-1:0]  i_display_width,
    output t_stage1             o_stage
);

    t_sample           r_low  [3];
    t_sample           r_high [3];
    logic [CNT_W-1:0]  r_inv;
    logic [CNT_W-1:0]  r_pos;
    t_stage1           r_stage;

    t_sample           base_low  [3];
    t_sample           base_high [3];
    logic [CNT_W-1:0]  base_inv;
    logic [CNT_W-1:0]  base_pos;
    t_sample           n_low  [3];
    t_sample           n_high [3];
    logic [CNT_W-1:0]  n_inv;
    logic [CNT_W-1:0]  n_pos;
    logic              is_end;
    logic              is_neg;
    logic              is_over;
    logic [SAMPLE_W:0] abs_val;
    logic [MAG_W-1:0]  mag;
    logic [CNT_W:0]    inv_sum;
    logic [WIDTH_W-1:0] width_cl;
    logic [SPAN_W-1:0] span;
    logic [PROD_W-1:0] prod;

    // Seed selection: first item of a set restarts everything from this sample
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            base_low[i]  = i_first ? i_sample : r_low[i];
            base_high[i] = i_first ? i_sample : r_high[i];
        end
        base_inv = i_first ? '0 : r_inv;
        base_pos = i_first ? '0 : r_pos;
    end

    assign is_end = (i_sample == SENTINEL);

    // Shift-insert into the three smallest
    always_comb begin
        for (int i = 0; i < 3; i++) n_low[i] = base_low[i];
        if (!is_end) begin
            priority if (i_sample < base_low[0]) begin
                n_low[2] = base_low[1];
                n_low[1] = base_low[0];
                n_low[0] = i_sample;
            end else if (i_sample < base_low[1]) begin
                n_low[2] = base_low[1];
                n_low[1] = i_sample;
            end else if (i_sample < base_low[2]) begin
                n_low[2] = i_sample;
            end
        end
    end

    // Shift-insert into the three largest
    always_comb begin
        for (int i = 0; i < 3; i++) n_high[i] = base_high[i];
        if (!is_end) begin
            priority if (i_sample > base_high[0]) begin
                n_high[2] = base_high[1];
                n_high[1] = base_high[0];
                n_high[0] = i_sample;
            end else if (i_sample > base_high[1]) begin
                n_high[2] = base_high[1];
                n_high[1] = i_sample;
            end else if (i_sample > base_high[2]) begin
                n_high[2] = i_sample;
            end
        end
    end

    // Magnitude, range clamp and flags
    assign is_neg  = !is_end && i_sample[SAMPLE_W-1];
    assign abs_val = i_sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {i_sample[SAMPLE_W-1], i_sample})
                                          : {1'b0, i_sample};
    assign is_over = !is_end && (abs_val > (SAMPLE_W+1)'(RANGE_LIMIT));
    assign mag     = (abs_val > (SAMPLE_W+1)'(RANGE_LIMIT)) ? MAG_W'(RANGE_LIMIT)
                                                            : abs_val[MAG_W-1:0];

    // Saturating counters
    assign inv_sum = {1'b0, base_inv} + (CNT_W+1)'(is_neg) + (CNT_W+1)'(is_over);
    assign n_inv   = inv_sum[CNT_W] ? '1 : inv_sum[CNT_W-1:0];
    assign n_pos   = (is_end || (&base_pos)) ? base_pos : base_pos + CNT_W'(1);

    // Bar span from the clamped display width
    always_comb begin
        priority if (i_display_width < WIDTH_MIN) width_cl = WIDTH_MIN;
        else if (i_display_width > WIDTH_MAX)     width_cl = WIDTH_MAX;
        else                                      width_cl = i_display_width;
    end
    assign span = SPAN_W'(width_cl - BAR_MARGIN);
    assign prod = PROD_W'(mag) * PROD_W'(span);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_low[i]  <= '0;
                r_high[i] <= '0;
            end
            r_inv <= '0;
            r_pos <= '0;
        end else if (i_advance) begin
            for (int i = 0; i < 3; i++) begin
                r_low[i]  <= n_low[i];
                r_high[i] <= n_high[i];
            end
            r_inv <= n_inv;
            r_pos <= n_pos;
        end
    end

    // Stage register toward the divide
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_stage.prod     <= prod;
            r_stage.neg      <= is_neg;
            r_stage.over     <= is_over;
            r_stage.end_mark <= is_end;
            r_stage.low0     <= n_low[0];
            r_stage.low1     <= n_low[1];
            r_stage.low2     <= n_low[2];
            r_stage.high0    <= n_high[0];
            r_stage.high1    <= n_high[1];
            r_stage.high2    <= n_high[2];
            r_stage.inv_cnt  <= n_inv;
            r_stage.pos_cnt  <= n_pos;
        end
    end

    assign o_stage = r_stage;

    // Trackers stay ordered
    a_low_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_low[0] <= r_low[1]) && (r_low[1] <= r_low[2]))
        else $error("low tracker out of order");

    a_high_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high[0] >= r_high[1]) && (r_high[1] >= r_high[2]))
        else $error("high tracker out of order");

    // Invalid items are always counted items
    a_inv_needs_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) |-> (r_inv == '0))
        else $error("invalid count without item count");

endmodule

// ===== hdl/bsc_scale.sv =====
// Bar width: product divided by the range limit via reciprocal multiply, plus one.
`timescale 1ns / 1ps

module bsc_scale
    import bsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_advance,
    input  t_stage1  i_stage,
    output t_result  o_result
);

    logic [PROD_W+RECIP_W-1:0] quot_full;
    logic [BAR_W-1:0]          n_bar;
    t_result                   r_result;

    // floor(prod / RANGE_LIMIT) + 1, zero on the sentinel
    assign quot_full = (PROD_W+RECIP_W)'(i_stage.prod) * (PROD_W+RECIP_W)'(RECIP_MULT);
    assign n_bar     = i_stage.end_mark ? '0
                                        : quot_full[RECIP_SHIFT +: BAR_W] + BAR_W'(1);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result.bar      <= n_bar;
            r_result.neg      <= i_stage.neg;
            r_result.over     <= i_stage.over;
            r_result.end_mark <= i_stage.end_mark;
            r_result.low0     <= i_stage.low0;
            r_result.low1     <= i_stage.low1;
            r_result.low2     <= i_stage.low2;
            r_result.high0    <= i_stage.high0;
            r_result.high1    <= i_stage.high1;
            r_result.high2    <= i_stage.high2;
            r_result.inv_cnt  <= i_stage.inv_cnt;
            r_result.pos_cnt  <= i_stage.pos_cnt;
        end
    end

    assign o_result = r_result;

endmodule

// ===== hdl/stream_top3_min_max_bar_scaler.sv =====
// Top level: stream ports, input register, three-stage pipeline control, config register.
//
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   s_axis_tvalid/tready       tdata: sample; tuser: first_of_set
//  m_axis    out  m_axis_tvalid/tready       tdata: bar..item_number; tlast: end_of_set
//  cfg       in   i_cfg_we                   i_cfg_wdata: display_width
//
//  One item per cycle sustained while m_axis_tready stays high; a result passes through three
//  registered stages in order (input register, tracker update + product, reciprocal divide).
//  Tracker state is updated as an item leaves the input register, so items chain in order.
//  Each stage holds while the next is full and stalled; tready ripples back from m_axis_tready.
//  Synchronous active-low reset clears trackers, counters, valids; display_width -> 80.
`timescale 1ns / 1ps

module stream_top3_min_max_bar_scaler
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_we,
    input  logic [WIDTH_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [15:0] sample
    input  logic                s_axis_tuser,   // [0] first_of_set
    // output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [8:0] bar_width, [9] was_negative, [10] was_over_range, [26:11] smallest,
    // [42:27] second_smallest, [58:43] third_smallest, [74:59] largest,
    // [90:75] second_largest, [106:91] third_largest, [122:107] invalid_total,
    // [138:123] item_number, [143:139] zero
    output logic [143:0]        m_axis_tdata,
    output logic                m_axis_tlast    // end_of_set
);

    logic               r_in_valid;
    logic               r_s1_valid;
    logic               r_out_valid;
    t_sample            r_sample;
    logic               r_first;
    logic [WIDTH_W-1:0] r_display_width;

    logic               in_acc;
    logic               out_ready;
    logic               s1_ready;
    logic               s0_adv;
    logic               s1_adv;
    t_stage1            stage1;
    t_result            result;

    // Pipeline handshake
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && out_ready;
    assign s1_ready      = !r_s1_valid || out_ready;
    assign s0_adv        = r_in_valid && s1_ready;
    assign s_axis_tready = !r_in_valid || s1_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_acc || (r_in_valid && !s0_adv);
            r_s1_valid  <= s0_adv || (r_s1_valid && !s1_adv);
            r_out_valid <= s1_adv || (r_out_valid && !m_axis_tready);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= s_axis_tdata;
            r_first  <= s_axis_tuser;
        end
    end

    // Display width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_width <= DISPLAY_RESET;
        end else if (i_cfg_we) begin
            r_display_width <= i_cfg_wdata;
        end
    end

    bsc_update u_update (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (s0_adv),
        .i_sample        (r_sample),
        .i_first         (r_first),
        .i_display_width (r_display_width),
        .o_stage         (stage1)
    );

    bsc_scale u_scale (
        .i_clk     (i_clk),
        .i_advance (s1_adv),
        .i_stage   (stage1),
        .o_result  (result)
    );

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = result.end_mark;
    assign m_axis_tdata  = {5'b0, result.pos_cnt, result.inv_cnt,
                            result.high2, result.high1, result.high0,
                            result.low2, result.low1, result.low0,
                            result.over, result.neg, result.bar};

    // Counted items always draw a bar of at least one
    a_bar_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (result.bar != '0))
        else $error("zero bar on a data item");

    // Sentinel result carries no bar and no flags
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (result.bar == '0 && !result.neg && !result.over))
        else $error("sentinel result with bar or flags");

    // An item moves out of the input register only when stage one can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |-> !s0_adv)
        else $error("stage one overwritten while stalled");

endmodule

// ===== dv/bar_tracker_checker.sv =====
// Checker for the top-3 min/max tracker: predicts each result item and compares it.
`timescale 1ns / 1ps

module bar_tracker_checker
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [WIDTH_W-1:0]  i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [15:0]         i_s_tdata,   // [15:0] sample
    input  logic                i_s_tuser,   // [0] first_of_set
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // [8:0] bar_width, [9] was_negative, [10] was_over_range, [26:11] smallest,
    // [42:27] second_smallest, [58:43] third_smallest, [74:59] largest,
    // [90:75] second_largest, [106:91] third_largest, [122:107] invalid_total,
    // [138:123] item_number, [143:139] zero
    input  logic [143:0]        i_m_tdata,
    input  logic                i_m_tlast,   // end_of_set
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_end_results,
    output int                  o_negatives,
    output int                  o_clamped
);

    // Shadow copy of the tracker state and the width register
    t_sample            low_q  [3];
    t_sample            high_q [3];
    logic [CNT_W-1:0]   invalid_q;
    logic [CNT_W-1:0]   position_q;
    logic [WIDTH_W-1:0] width_q;

    t_result pending_results [$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_results     = 0;
        o_end_results = 0;
        o_negatives   = 0;
        o_clamped     = 0;
    end

    function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Apply one sample to the shadow state and return the result it should give
    function automatic t_result advance_trackers(t_sample s, logic first);
        t_result            r;
        int                 mag;
        int                 span;
        logic [WIDTH_W-1:0] w;
        r = '0;
        if (first) begin
            for (int i = 0; i < 3; i++) begin
                low_q[i]  = s;
                high_q[i] = s;
            end
            invalid_q  = '0;
            position_q = '0;
        end
        if (s != SENTINEL) begin
            // shift-insert into the three smallest
            if (s < low_q[0]) begin
                low_q[2] = low_q[1];
                low_q[1] = low_q[0];
                low_q[0] = s;
            end else if (s < low_q[1]) begin
                low_q[2] = low_q[1];
                low_q[1] = s;
            end else if (s < low_q[2]) begin
                low_q[2] = s;
            end
            // shift-insert into the three largest
            if (s > high_q[0]) begin
                high_q[2] = high_q[1];
                high_q[1] = high_q[0];
                high_q[0] = s;
            end else if (s > high_q[1]) begin
                high_q[2] = high_q[1];
                high_q[1] = s;
            end else if (s > high_q[2]) begin
                high_q[2] = s;
            end
            // magnitude, clamp and invalid count
            mag = int'(s);
            if (mag < 0) begin
                r.neg     = 1'b1;
                mag       = -mag;
                invalid_q = sat_bump(invalid_q);
            end
            if (mag > RANGE_LIMIT) begin
                r.over    = 1'b1;
                mag       = RANGE_LIMIT;
                invalid_q = sat_bump(invalid_q);
            end
            // bar scaled to the clamped display width
            w = width_q;
            if (w < WIDTH_MIN) w = WIDTH_MIN;
            if (w > WIDTH_MAX) w = WIDTH_MAX;
            span       = int'(w) - int'(BAR_MARGIN);
            r.bar      = BAR_W'(mag * span / RANGE_LIMIT + 1);
            position_q = sat_bump(position_q);
        end
        r.end_mark = (s == SENTINEL);
        r.low0     = low_q[0];
        r.low1     = low_q[1];
        r.low2     = low_q[2];
        r.high0    = high_q[0];
        r.high1    = high_q[1];
        r.high2    = high_q[2];
        r.inv_cnt  = invalid_q;
        r.pos_cnt  = position_q;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            o_fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Watch both channels and the config port on every edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                low_q[i]  = '0;
                high_q[i] = '0;
            end
            invalid_q  = '0;
            position_q = '0;
            width_q    = DISPLAY_RESET;
        end else begin
            if (i_cfg_we)
                width_q = i_cfg_wdata;

            // accepted input item
            if (i_s_tvalid && i_s_tready) begin
                want = advance_trackers(t_sample'(i_s_tdata), i_s_tuser);
                pending_results.push_back(want);
                o_negatives += want.neg;
                o_clamped   += want.over;
            end

            // accepted result item
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    $error("result item with no input item pending");
                end else begin
                    want = pending_results.pop_front();
                    o_results++;
                    o_end_results += want.end_mark;
                    check_field("bar_width", want.bar, i_m_tdata[8:0]);
                    check_field("was_negative", want.neg, i_m_tdata[9]);
                    check_field("was_over_range", want.over, i_m_tdata[10]);
                    check_field("smallest", want.low0, $signed(i_m_tdata[26:11]));
                    check_field("second_smallest", want.low1, $signed(i_m_tdata[42:27]));
                    check_field("third_smallest", want.low2, $signed(i_m_tdata[58:43]));
                    check_field("largest", want.high0, $signed(i_m_tdata[74:59]));
                    check_field("second_largest", want.high1, $signed(i_m_tdata[90:75]));
                    check_field("third_largest", want.high2, $signed(i_m_tdata[106:91]));
                    check_field("invalid_total", want.inv_cnt, i_m_tdata[122:107]);
                    check_field("item_number", want.pos_cnt, i_m_tdata[138:123]);
                    check_field("padding", 0, i_m_tdata[143:139]);
                    check_field("end_of_set", want.end_mark, i_m_tlast);
                end
            end
            o_pending = pending_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, stimulus and verdict for the top-3 min/max bar scaler.
`timescale 1ns / 1ps

module testbench;
    import bsc_pkg::*;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [WIDTH_W-1:0]  i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;   // [15:0] sample
    logic                s_axis_tuser  = 1'b0; // [0] first_of_set
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [143:0]        m_axis_tdata;         // bar_width .. item_number, see checker
    logic                m_axis_tlast;         // end_of_set

    int fail_count, pending, results, end_results, negatives, clamped;
    int items_sent   = 0;
    int width_writes = 0;
    bit quiet        = 1'b0;   // no idling on either side while set

    always #10 i_clk = ~i_clk;

    stream_top3_min_max_bar_scaler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bar_tracker_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_end_results (end_results),
        .o_negatives   (negatives),
        .o_clamped     (clamped)
    );

    // Result side: stall now and then
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 6);
    end

    // Hand one item to the block, with an occasional gap first
    task automatic push_sample(t_sample s, logic first);
        while (!quiet && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] w);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        width_writes++;
    endtask

    // Mix of limit-straddling, full-range, extreme and tie-prone samples
    function automatic t_sample pick_sample();
        int extremes [8] = '{-32768, 32767, 112, 113, -112, -113, 0, -1};
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: return t_sample'(int'($urandom_range(300)) - 150);
            6, 7, 8, 9:       return t_sample'($urandom);
            10, 11:           return t_sample'(extremes[$urandom_range(7)]);
            12, 13, 14:       return t_sample'(int'($urandom_range(20)) - 10);
            15:               return SENTINEL;
            default:          return t_sample'($urandom_range(112));
        endcase
    endfunction

    // Directed part: unseeded start, extremes, insert paths, sentinel cases
    int dir_sample [$] = '{50, -5, 0,
                           10, 32767, -32768, 112, 113, -112, -113, 1, -1, 10000, 9999,
                           0, 100, 50, 75, 60, -20, -10, -15,
                           9999, 3, 9999};
    bit dir_first  [$] = '{0, 0, 0,
                           1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                           1, 0, 0, 0, 0, 0, 0, 0,
                           1, 0, 0};

    logic [WIDTH_W-1:0] phase_width [8] = '{10'd0, 10'd1023, 10'd5, 10'd512,
                                            10'd4, 10'd513, 10'd300, 10'd80};

    initial begin
        int set_len;
        int phase_items;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at the reset width
        foreach (dir_sample[i])
            push_sample(t_sample'(dir_sample[i]), dir_first[i]);
        drain();

        // random sets over a range of display widths
        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                phase_width[p] = 10'($urandom_range(1023));
            write_width(phase_width[p]);
            quiet = (p == 2);
            phase_items = 0;
            while (phase_items < 104) begin
                // an occasional set without its seed item
                if ($urandom_range(7) != 0) begin
                    push_sample(pick_sample(), 1'b1);
                    phase_items++;
                end
                set_len = $urandom_range(30, 1);
                repeat (set_len) begin
                    push_sample(pick_sample(), $urandom_range(49) == 0);
                    phase_items++;
                end
                if ($urandom_range(4) != 0) begin
                    push_sample(SENTINEL, 1'b0);
                    phase_items++;
                end
            end
            drain();
        end
        quiet = 1'b0;

        // wait out the last results
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d items over %0d width settings, %0d results checked.",
                 items_sent, width_writes, results);
        $display("Seen: %0d end-of-set results, %0d negative and %0d clamped samples.",
                 end_results, negatives, clamped);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bsc_pkg.sv
hdl/bsc_update.sv
hdl/bsc_scale.sv
hdl/stream_top3_min_max_bar_scaler.sv
dv/bar_tracker_checker.sv
dv/testbench.sv
